/* hw/rtl/vcrd_pkg.sv */
// Shared types and constants for the voxel column run-length decoder.
`default_nettype none

package vcrd_pkg;

  localparam int unsigned MaxDim = 1024;
  localparam int unsigned DimCap = (MaxDim > 1024) ? 1024 : MaxDim;

  localparam int unsigned CoordW = 10;
  localparam int unsigned CountW = 11;

  localparam logic [CountW-1:0] CoordLimit = CountW'(DimCap - 1);
  localparam logic [CountW-1:0] CoordSat   = CountW'(DimCap);
  localparam logic [CountW-1:0] DepthMax   = 11'd1024;

  localparam logic [7:0] AlphaMarker = 8'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       matrix_start;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_z;
    logic [CoordW-1:0] start_y;
    logic [7:0]        run_length;
    logic [31:0]       colour;
    logic              range_error;
  } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/vcrd_in_reg.sv */
// Input register stage holding one payload byte transaction.
`default_nettype none

module vcrd_in_reg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire vcrd_pkg::in_item_t in_data_i,
  input  wire                     take_i,
  output logic                    valid_o,
  output vcrd_pkg::in_item_t      item_o
);

  logic               valid_q;
  logic               valid_d;
  vcrd_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/vcrd_parser.sv */
// Column parser: count and word assembly, run decode and coordinate tracking.
`default_nettype none

module vcrd_parser (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       step_i,
  input  wire vcrd_pkg::in_item_t   item_i,
  input  wire [vcrd_pkg::CountW-1:0] depth_i,
  output logic                      res_valid_o,
  output vcrd_pkg::out_item_t       res_o
);

  localparam logic [1:0] PhCntLo  = 2'd0;
  localparam logic [1:0] PhCntHi  = 2'd1;
  localparam logic [1:0] PhWord   = 2'd2;
  localparam logic [1:0] PhRunCol = 2'd3;

  logic [1:0]                   phase_q, phase_d, phase_c;
  logic [1:0]                   idx_q, idx_d, idx_c;
  logic [23:0]                  asm_q, asm_d, asm_c;
  logic [15:0]                  words_q, words_d, words_c;
  logic [7:0]                   run_q, run_d, run_c;
  logic [vcrd_pkg::CountW-1:0]  y_q, y_d, y_c;
  logic [vcrd_pkg::CountW-1:0]  x_q, x_d, x_c;
  logic [vcrd_pkg::CoordW-1:0]  z_q, z_d, z_c;

  logic [31:0]                  word;
  logic [15:0]                  words_left;
  logic [15:0]                  words_dec;
  logic [vcrd_pkg::CountW-1:0]  z_inc;
  logic [7:0]                   adv_len;
  logic                         adv_en;
  logic                         col_end;
  logic [vcrd_pkg::CountW:0]    y_sum;
  logic [vcrd_pkg::CountW:0]    y_top;
  logic                         emit;
  logic [7:0]                   emit_len;

  always_comb begin
    phase_c = item_i.matrix_start ? PhCntLo : phase_q;
    idx_c   = item_i.matrix_start ? 2'd0 : idx_q;
    asm_c   = item_i.matrix_start ? '0 : asm_q;
    words_c = item_i.matrix_start ? '0 : words_q;
    run_c   = item_i.matrix_start ? '0 : run_q;
    y_c     = item_i.matrix_start ? '0 : y_q;
    x_c     = item_i.matrix_start ? '0 : x_q;
    z_c     = item_i.matrix_start ? '0 : z_q;
  end

  assign word       = {item_i.data_byte, asm_c};
  assign words_left = {item_i.data_byte, words_c[7:0]};
  assign words_dec  = (words_c != 16'd0) ? (words_c - 16'd1) : words_c;
  assign z_inc      = {1'b0, z_c} + 11'd1;
  assign y_sum      = {1'b0, y_c} + {4'd0, adv_len};
  assign y_top      = {1'b0, y_c} + {4'd0, emit_len};

  always_comb begin
    phase_d  = phase_c;
    idx_d    = idx_c;
    asm_d    = asm_c;
    words_d  = words_c;
    run_d    = run_c;
    y_d      = y_c;
    x_d      = x_c;
    z_d      = z_c;
    adv_len  = 8'd0;
    adv_en   = 1'b0;
    col_end  = 1'b0;
    emit     = 1'b0;
    emit_len = 8'd1;

    case (phase_c)
      PhCntLo: begin
        words_d = {8'd0, item_i.data_byte};
        phase_d = PhCntHi;
      end
      PhCntHi: begin
        words_d = words_left;
        if (words_left == 16'd0) begin
          col_end = 1'b1;
        end else begin
          phase_d = PhWord;
          idx_d   = 2'd0;
          asm_d   = '0;
        end
      end
      default: begin
        if (idx_c != 2'd3) begin
          case (idx_c)
            2'd0:    asm_d[7:0]   = item_i.data_byte;
            2'd1:    asm_d[15:8]  = item_i.data_byte;
            default: asm_d[23:16] = item_i.data_byte;
          endcase
          idx_d = idx_c + 2'd1;
        end else begin
          idx_d   = 2'd0;
          asm_d   = '0;
          words_d = words_dec;
          if (phase_c == PhWord && word[31:24] == vcrd_pkg::AlphaMarker) begin
            run_d   = word[7:0];
            phase_d = PhRunCol;
          end else begin
            if (phase_c == PhWord) begin
              emit    = (word[31:24] != 8'd0);
              adv_len = 8'd1;
            end else begin
              emit     = (word[31:24] != 8'd0) && (run_c != 8'd0);
              emit_len = run_c;
              adv_len  = run_c;
              run_d    = 8'd0;
            end
            adv_en = 1'b1;
            if (words_dec == 16'd0) begin
              col_end = 1'b1;
            end else begin
              phase_d = PhWord;
            end
          end
        end
      end
    endcase

    if (adv_en) begin
      y_d = (y_sum > {1'b0, vcrd_pkg::CoordSat}) ? vcrd_pkg::CoordSat
                                                 : y_sum[vcrd_pkg::CountW-1:0];
    end

    if (col_end) begin
      y_d     = '0;
      phase_d = PhCntLo;
      if (z_inc >= depth_i) begin
        z_d = '0;
        if (x_c <= vcrd_pkg::CoordLimit) begin
          x_d = x_c + 11'd1;
        end
      end else begin
        z_d = z_inc[vcrd_pkg::CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCntLo;
      idx_q   <= 2'd0;
      asm_q   <= '0;
      words_q <= '0;
      run_q   <= '0;
      y_q     <= '0;
      x_q     <= '0;
      z_q     <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      asm_q   <= asm_d;
      words_q <= words_d;
      run_q   <= run_d;
      y_q     <= y_d;
      x_q     <= x_d;
      z_q     <= z_d;
    end
  end

  always_comb begin
    res_valid_o       = emit;
    res_o.pos_x       = (x_c > vcrd_pkg::CoordLimit)
                        ? vcrd_pkg::CoordLimit[vcrd_pkg::CoordW-1:0]
                        : x_c[vcrd_pkg::CoordW-1:0];
    res_o.pos_z       = ({1'b0, z_c} > vcrd_pkg::CoordLimit)
                        ? vcrd_pkg::CoordLimit[vcrd_pkg::CoordW-1:0] : z_c;
    res_o.start_y     = (y_c > vcrd_pkg::CoordLimit)
                        ? vcrd_pkg::CoordLimit[vcrd_pkg::CoordW-1:0]
                        : y_c[vcrd_pkg::CoordW-1:0];
    res_o.run_length  = emit_len;
    res_o.colour      = word;
    res_o.range_error = (x_c > vcrd_pkg::CoordLimit)
                        || ({1'b0, z_c} > vcrd_pkg::CoordLimit)
                        || (y_top > {1'b0, vcrd_pkg::CoordSat});
  end

endmodule

`default_nettype wire

/* hw/rtl/vcrd_out_reg.sv */
// Output register holding one voxel run transaction until taken.
`default_nettype none

module vcrd_out_reg (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      load_i,
  input  wire vcrd_pkg::out_item_t res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output vcrd_pkg::out_item_t      out_data_o
);

  logic                valid_q;
  logic                valid_d;
  vcrd_pkg::out_item_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/voxel_column_rle_decoder.sv */
// Top level of the voxel column run-length decoder.
//
//   channel  direction  payload                 transaction
//   in       input      vcrd_pkg::in_item_t     one matrix payload byte
//   out      output     vcrd_pkg::out_item_t    one visible voxel run
//   cfg      input      depth_z, 11 bits        write of the depth register
//
// One byte per cycle sustained while the output is not stalled; each byte is held
// in the input register, then its parser result loads the result register.
// Reset clears all parser counters, both stage valids, and sets depth_z to 1.
// A stalled output holds the result; one more byte waits in the input register.
`default_nettype none

module voxel_column_rle_decoder (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire vcrd_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output vcrd_pkg::out_item_t     out_data_o,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire [10:0]              cfg_data_i
);

  logic [10:0]                  depth_q;
  logic [vcrd_pkg::CountW-1:0]  depth_eff;
  logic                         item_valid;
  vcrd_pkg::in_item_t           item;
  logic                         out_free;
  logic                         step;
  logic                         res_valid;
  vcrd_pkg::out_item_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 11'd1;
    end else if (cfg_valid_i) begin
      depth_q <= cfg_data_i;
    end
  end

  assign depth_eff = (depth_q == 11'd0) ? 11'd1
                   : (depth_q > vcrd_pkg::DepthMax) ? vcrd_pkg::DepthMax : depth_q;

  assign step = item_valid && out_free;

  vcrd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (step),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  vcrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .depth_i     (depth_eff),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vcrd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/vcrd_tb_pkg.sv */
// Run predictor and scoreboard for the voxel column run-length decoder testbench.
`timescale 1ns / 100ps

package vcrd_tb_pkg;
  import vcrd_pkg::*;

  localparam int unsigned CoordMax = DimCap - 1;
  localparam logic [7:0] AlphaEmpty = 8'd0;

  typedef enum logic [1:0] {CountLow, CountHigh, ColourWord, RunColour} parse_phase_e;

  class run_scoreboard;
    out_item_t    expected_runs[$];
    int unsigned  mismatches;
    int unsigned  runs_checked;
    int unsigned  clipped_runs;
    int unsigned  bytes_taken;
    logic [10:0]  depth_reg;
    parse_phase_e phase;
    logic [1:0]   byte_idx;
    logic [31:0]  word_acc;
    logic [15:0]  words_left;
    logic [7:0]   run_len;
    logic [10:0]  col_x;
    logic [10:0]  col_y;
    logic [10:0]  col_z;

    function new();
      mismatches   = 0;
      runs_checked = 0;
      clipped_runs = 0;
      bytes_taken  = 0;
      depth_reg    = 11'd1;
      clear_matrix();
    endfunction

    function void clear_matrix();
      phase      = CountLow;
      byte_idx   = '0;
      word_acc   = '0;
      words_left = '0;
      run_len    = '0;
      col_x      = '0;
      col_y      = '0;
      col_z      = '0;
    endfunction

    function void set_depth(logic [10:0] value);
      depth_reg = value;
    endfunction

    function void close_column();
      int unsigned span;
      span = depth_reg;
      if (span == 0) span = 1;
      if (span > DepthMax) span = DepthMax;
      col_y = '0;
      col_z = col_z + 1'b1;
      if (col_z >= span) begin
        col_z = '0;
        if (col_x <= CoordMax) col_x = col_x + 1'b1;
      end
      phase = CountLow;
    endfunction

    function void step_y(int unsigned len);
      int unsigned y;
      y = col_y + len;
      if (y > CoordMax + 1) y = CoordMax + 1;
      col_y = 11'(y);
    endfunction

    function void push_run(logic [7:0] len, logic [31:0] colour);
      out_item_t r;
      r.range_error = (col_x > CoordMax) || (col_z > CoordMax) ||
                      (32'(col_y) + 32'(len) - 1 > CoordMax);
      r.pos_x       = (col_x > CoordMax) ? 10'(CoordMax) : col_x[CoordW-1:0];
      r.pos_z       = (col_z > CoordMax) ? 10'(CoordMax) : col_z[CoordW-1:0];
      r.start_y     = (col_y > CoordMax) ? 10'(CoordMax) : col_y[CoordW-1:0];
      r.run_length  = len;
      r.colour      = colour;
      if (r.range_error) clipped_runs++;
      expected_runs.push_back(r);
    endfunction

    function void note_byte(in_item_t item);
      logic [31:0] w;
      logic [7:0]  alpha;
      bytes_taken++;
      if (item.matrix_start) clear_matrix();
      case (phase)
        CountLow: begin
          words_left = {8'h00, item.data_byte};
          phase = CountHigh;
          return;
        end
        CountHigh: begin
          words_left[15:8] = item.data_byte;
          if (words_left == 0) begin
            close_column();
          end else begin
            phase    = ColourWord;
            byte_idx = '0;
            word_acc = '0;
          end
          return;
        end
        default: ;
      endcase
      word_acc = word_acc | (32'(item.data_byte) << (8 * byte_idx));
      if (byte_idx != 2'd3) begin
        byte_idx = byte_idx + 1'b1;
        return;
      end
      byte_idx = '0;
      w        = word_acc;
      word_acc = '0;
      alpha    = w[31:24];
      if (words_left != 0) words_left = words_left - 1'b1;
      if (phase == ColourWord) begin
        if (alpha == AlphaMarker) begin
          run_len = w[7:0];
          phase   = RunColour;
          return;
        end
        if (alpha != AlphaEmpty) push_run(8'd1, w);
        step_y(1);
      end else begin
        if (alpha != AlphaEmpty && run_len != 0) push_run(run_len, w);
        step_y(run_len);
        run_len = '0;
      end
      if (words_left == 0) close_column();
      else phase = ColourWord;
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected x=%0d z=%0d y=%0d len=%0d colour=%h err=%0d, got x=%0d z=%0d y=%0d len=%0d colour=%h err=%0d",
                 what, want.pos_x, want.pos_z, want.start_y, want.run_length,
                 want.colour, want.range_error, got.pos_x, got.pos_z, got.start_y,
                 got.run_length, got.colour, got.range_error);
    endfunction

    function void check_run(out_item_t got);
      out_item_t want;
      if (expected_runs.size() == 0) begin
        report("unexpected run", '0, got);
        return;
      end
      want = expected_runs.pop_front();
      runs_checked++;
      if (got.pos_x !== want.pos_x || got.pos_z !== want.pos_z ||
          got.start_y !== want.start_y || got.run_length !== want.run_length ||
          got.colour !== want.colour || got.range_error !== want.range_error)
        report("run mismatch", want, got);
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
// Top-level testbench for the voxel column run-length decoder.
`timescale 1ns / 100ps

module testbench;
  import vcrd_pkg::*;
  import vcrd_tb_pkg::*;

  localparam int unsigned RandomBytes  = 600;
  localparam int unsigned QuietFrom    = 480;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 8;

  typedef enum logic [1:0] {EmptyWord, SolidWord, RunPair} word_kind_e;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [10:0] cfg_data  = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_data_o;
  logic        cfg_ready_o;

  bit          quiet        = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  int unsigned random_bytes = 0;
  int unsigned depth_writes = 0;
  run_scoreboard sb;

  voxel_column_rle_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) sb.check_run(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(in_item_t item);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(item);
  endtask

  task automatic send_stream(ref in_item_t q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.set_depth(value);
    depth_writes++;
  endtask

  function automatic void add_byte(ref in_item_t q[$], input logic [7:0] b,
                                   input logic start);
    in_item_t item;
    item.data_byte    = b;
    item.matrix_start = start;
    q.push_back(item);
  endfunction

  function automatic void add_count(ref in_item_t q[$], input logic [15:0] n);
    add_byte(q, n[7:0], 1'b0);
    add_byte(q, n[15:8], 1'b0);
  endfunction

  function automatic void add_word(ref in_item_t q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(q, w[8*i +: 8], 1'b0);
  endfunction

  function automatic logic [31:0] visible_word();
    logic [31:0] w;
    w = $urandom();
    if (w[31:24] == AlphaEmpty || w[31:24] == AlphaMarker) w[31:24] = 8'hFF;
    return w;
  endfunction

  function automatic logic [31:0] run_colour();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 3))
      0: w[31:24] = AlphaEmpty;
      1: w[31:24] = AlphaMarker;
      default: ;
    endcase
    return w;
  endfunction

  function automatic void add_column(ref in_item_t q[$], input bit tall);
    int unsigned left;
    word_kind_e  kind;
    logic [7:0]  len;
    if (tall) left = $urandom_range(10, 14);
    else if ($urandom_range(0, 4) == 0) left = 0;
    else left = $urandom_range(1, 7);
    add_count(q, 16'(left));
    while (left != 0) begin
      kind = tall ? RunPair : word_kind_e'($urandom_range(0, 2));
      case (kind)
        EmptyWord: begin
          add_word(q, {AlphaEmpty, 24'($urandom())});
          left--;
        end
        SolidWord: begin
          add_word(q, visible_word());
          left--;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: len = 8'd0;
            1: len = 8'd255;
            2: len = 8'd1;
            default: len = tall ? 8'($urandom_range(180, 255)) : 8'($urandom());
          endcase
          add_word(q, {AlphaMarker, 16'($urandom()), len});
          add_word(q, run_colour());
          left = (left > 2) ? left - 2 : 0;
        end
      endcase
    end
  endfunction

  function automatic void add_matrix(ref in_item_t q[$], input int unsigned cols);
    int unsigned first;
    first = q.size();
    repeat (cols) add_column(q, $urandom_range(0, 7) == 0);
    q[first].matrix_start = 1'b1;
  endfunction

  function automatic logic [10:0] pick_depth(int unsigned n);
    case (n)
      0: return '1;
      1: return DepthMax;
      2: return 11'd3;
      3: return 11'd0;
      4: return 11'd1;
      default: return ($urandom_range(0, 9) == 0) ? 11'($urandom())
                                                  : 11'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    in_item_t    stream[$];
    in_item_t    chunk[$];
    int unsigned phase_no;
    int unsigned cut;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_count(stream, 16'd4);
    stream[0].matrix_start = 1'b1;
    add_word(stream, 32'hFFFF_FFFF);
    add_word(stream, {AlphaEmpty, 24'h123456});
    add_word(stream, {AlphaMarker, 16'h0000, 8'hFF});
    add_word(stream, {AlphaMarker, 24'hABCDEF});
    add_count(stream, 16'd0);
    add_count(stream, 16'd1);
    add_word(stream, {AlphaMarker, 16'hFFFF, 8'h00});
    add_word(stream, 32'hFF00_0000);
    add_count(stream, 16'd2);
    add_word(stream, 32'h0100_0000);
    add_byte(stream, 8'hA5, 1'b0);
    add_byte(stream, 8'h5A, 1'b0);
    send_stream(stream);
    drain();

    phase_no = 0;
    while (random_bytes < RandomBytes) begin
      drain();
      quiet = (random_bytes >= QuietFrom);
      write_depth(pick_depth(phase_no));
      stream.delete();
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(4, 16))
               add_byte(stream, 8'($urandom()), $urandom_range(0, 7) == 0);
          1: repeat ($urandom_range(1, 3)) add_column(stream, 1'b0);
          2: begin
            chunk.delete();
            add_matrix(chunk, $urandom_range(1, 3));
            cut = $urandom_range(1, chunk.size() - 1);
            for (int i = 0; i < cut; i++) stream.push_back(chunk[i]);
          end
          default: add_matrix(stream, $urandom_range(1, 4));
        endcase
      end
      send_stream(stream);
      random_bytes += stream.size();
      phase_no++;
    end
    drain();

    $display("Covered %0d payload bytes under %0d depth settings, tall columns included.",
             sb.bytes_taken, depth_writes);
    $display("Checked %0d voxel runs, %0d of them clipped; %0d mismatches.",
             sb.runs_checked, sb.clipped_runs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
